@@ hw/rtl/tsl_pkg.sv @@
package tsl_pkg;

  localparam int CharW = 8;
  localparam int KindW = 2;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_STRING = 2'd1,
    MODE_NUMBER = 2'd2,
    MODE_WORD   = 2'd3
  } mode_t;

  typedef enum logic [KindW-1:0] {
    KIND_STRING = 2'd0,
    KIND_NUMBER = 2'd1,
    KIND_WORD   = 2'd2
  } kind_t;

  localparam logic [CharW-1:0] ChQuote     = 8'h22;
  localparam logic [CharW-1:0] ChMinus     = 8'h2D;
  localparam logic [CharW-1:0] ChDot       = 8'h2E;
  localparam logic [CharW-1:0] ChBackslash = 8'h5C;
  localparam logic [CharW-1:0] ChLowerN    = 8'h6E;
  localparam logic [CharW-1:0] ChNewline   = 8'h0A;

  // Lexer state that survives between transfers.
  typedef struct packed {
    mode_t             mode;
    logic              held_valid;
    logic [CharW-1:0]  held_char;
    kind_t             held_kind;
    logic              held_is_last;
  } lex_state_t;

  // One character of a token on its way out.
  typedef struct packed {
    logic [CharW-1:0]  token_char;
    kind_t             token_kind;
    logic              token_last;
    logic              unterminated;
  } lex_result_t;

  function automatic logic is_space(input logic [CharW-1:0] c);
    return (c inside {8'd32, [8'd9:8'd13]});
  endfunction

  function automatic logic is_digit(input logic [CharW-1:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  // Token kind that a mode produces; idle falls back to the string kind.
  function automatic kind_t mode_kind(input mode_t m);
    kind_t k;
    case (m)
      MODE_STRING: k = KIND_STRING;
      MODE_NUMBER: k = KIND_NUMBER;
      MODE_WORD:   k = KIND_WORD;
      default:     k = KIND_STRING;
    endcase
    return k;
  endfunction

  // Mode entered by a non-whitespace character that opens a token.
  function automatic mode_t start_mode(input logic [CharW-1:0] c);
    mode_t m;
    if (c == ChQuote) begin
      m = MODE_STRING;
    end else if (is_digit(c) || c == ChMinus) begin
      m = MODE_NUMBER;
    end else begin
      m = MODE_WORD;
    end
    return m;
  endfunction

endpackage

@@ hw/rtl/tsl_step.sv @@
module tsl_step
  import tsl_pkg::*;
(
  input  lex_state_t        cur,
  input  logic [CharW-1:0]  char_code,
  input  logic              end_of_source,
  output lex_state_t        nxt,
  output logic              res_valid,
  output lex_result_t       res
);

  mode_t sm;
  logic  escape_hit;

  assign sm = start_mode(char_code);

  // Backslash-n collapses into one newline, nothing leaves this time.
  assign escape_hit = !end_of_source && (cur.mode == MODE_STRING) && cur.held_valid &&
                      (cur.held_char == ChBackslash) && (char_code == ChLowerN);

  // Next lexer state.
  always_comb begin
    nxt = cur;
    if (end_of_source) begin
      nxt.mode = MODE_IDLE;
      nxt.held_valid = 1'b0;
      nxt.held_is_last = 1'b0;
    end else if (escape_hit) begin
      nxt.held_char = ChNewline;
    end else begin
      // Every other case sends the held character on and holds the new one unless it is whitespace outside a string.
      nxt.held_valid = 1'b0;
      nxt.held_is_last = 1'b0;
      case (cur.mode)
        MODE_STRING: begin
          nxt.held_valid = 1'b1;
          nxt.held_char = char_code;
          nxt.held_kind = KIND_STRING;
          if (char_code == ChQuote) begin
            nxt.held_is_last = 1'b1;
            nxt.mode = MODE_IDLE;
          end
        end
        MODE_WORD: begin
          if (is_space(char_code)) begin
            nxt.mode = MODE_IDLE;
          end else begin
            nxt.held_valid = 1'b1;
            nxt.held_char = char_code;
            nxt.held_kind = KIND_WORD;
          end
        end
        default: begin
          if (cur.mode == MODE_NUMBER && (is_digit(char_code) || char_code == ChDot)) begin
            nxt.held_valid = 1'b1;
            nxt.held_char = char_code;
            nxt.held_kind = KIND_NUMBER;
          end else begin
            // End of the previous token; this character may open the next.
            if (is_space(char_code)) begin
              nxt.mode = MODE_IDLE;
            end else begin
              nxt.mode = sm;
              nxt.held_valid = 1'b1;
              nxt.held_char = char_code;
              nxt.held_kind = mode_kind(sm);
            end
          end
        end
      endcase
    end
  end

  // The held character leaves unless an escape rewrites it in place.
  always_comb begin
    res_valid = cur.held_valid && !escape_hit;
    res.token_char = cur.held_char;
    res.token_kind = cur.held_kind;
    res.unterminated = end_of_source && (cur.mode == MODE_STRING) && !cur.held_is_last;
    case (cur.mode)
      MODE_STRING: begin
        res.token_last = end_of_source;
      end
      MODE_WORD: begin
        res.token_last = end_of_source || is_space(char_code);
      end
      MODE_NUMBER: begin
        res.token_last = end_of_source ||
                         !(is_digit(char_code) || char_code == ChDot);
      end
      default: begin
        res.token_last = 1'b1;
      end
    endcase
  end

endmodule

@@ hw/rtl/tsl_out_reg.sv @@
module tsl_out_reg
  import tsl_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  lex_result_t  res,
  output logic         can_load,
  output logic         out_valid,
  input  logic         out_ready,
  output lex_result_t  out_res
);

  // A new result may enter when the register is empty or drains this cycle.
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      out_res <= res;
    end
  end

endmodule

@@ hw/rtl/token_stream_lexer.sv @@
// Channel  Direction  Transfer carries
// -------  ---------  ----------------------------------------------------------
// s_*      in         one source character, or an end-of-source marker
// m_*      out        one token character with its kind, last and error flags
//
// Every input transfer is handled in the cycle it is accepted: the lexer state
// is updated and at most one result is written into the output register.
// A new character is accepted every cycle as long as the
// output register is empty or is being drained in the same cycle.
// Results appear in the cycle after the input transfer that causes them.
// Reset (rst, synchronous) returns the lexer to idle with nothing held back.
// A stalled m_tready only holds off s_tready; no result is ever dropped.
module token_stream_lexer
  import tsl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic [0:0]  s_tuser,   // [0] end_of_source
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] token_char
  output logic [2:0]  m_tuser,   // [1:0] token_kind, [2] unterminated
  output logic        m_tlast    // token_last
);

  lex_state_t  state;
  lex_state_t  state_next;
  logic        res_valid;
  lex_result_t res;
  lex_result_t out_res;
  logic        can_load;
  logic        in_xfer;

  assign s_tready = can_load;
  assign in_xfer = s_tvalid && s_tready;

  tsl_step u_step (
    .cur           (state),
    .char_code     (s_tdata),
    .end_of_source (s_tuser[0]),
    .nxt           (state_next),
    .res_valid     (res_valid),
    .res           (res)
  );

  // The lexer state only moves on an accepted input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode <= MODE_IDLE;
      state.held_valid <= 1'b0;
      state.held_char <= '0;
      state.held_kind <= KIND_STRING;
      state.held_is_last <= 1'b0;
    end else if (in_xfer) begin
      state <= state_next;
    end
  end

  tsl_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (in_xfer && res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = out_res.token_char;
  assign m_tuser = {out_res.unterminated, out_res.token_kind};
  assign m_tlast = out_res.token_last;

  // An unterminated flag only closes a string token.
  a_unterm_is_last_string: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tlast && (m_tuser[1:0] == KIND_STRING))
    else $error("unterminated flag on a non-final or non-string character");

  // Between tokens the only held character is a closing quote.
  a_idle_hold_is_quote: assert property (@(posedge clk) disable iff (rst)
    (state.mode == MODE_IDLE) && state.held_valid |->
      state.held_is_last && (state.held_char == ChQuote))
    else $error("idle lexer holds a character other than a closing quote");

  // A character known to be final is always a held string character.
  a_final_held_string: assert property (@(posedge clk) disable iff (rst)
    state.held_is_last |-> state.held_valid && (state.held_kind == KIND_STRING))
    else $error("final marker on a held character that is not a string quote");

  // A transfer that yields a result always has room in the output register.
  a_result_has_room: assert property (@(posedge clk) disable iff (rst)
    in_xfer && res_valid |=> m_tvalid)
    else $error("result of an accepted transfer was lost");

endmodule
